// File: sv/hts_pkg.sv
// Shared types, codes and constants for the humidity/temperature sensor sequencer.
// No dependencies; every other file of the block imports this package.
package hts_pkg;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// sensor command bytes
	localparam logic [7:0]  SOFT_RESET_CMD = 8'hBA;
	localparam logic [7:0]  STATUS_CMD     = 8'h71;
	localparam logic [23:0] TRIGGER_CMD    = 24'hAC3300;
	localparam int          BUSY_BIT       = 7;
	localparam int          CAL_BIT        = 3;

	// fixed-point conversion: value = (raw * scale + 2^19) >> 20
	localparam int          PROD_W      = 36;
	localparam logic [35:0] HUM_SCALE   = 36'd10000;
	localparam logic [35:0] TEMP_SCALE  = 36'd20000;
	localparam logic [35:0] ROUND_HALF  = 36'h80000;
	localparam logic [15:0] HUM_MAX     = 16'd10000;
	localparam logic [14:0] TEMP_OFFSET = 15'd5000;

	localparam logic [9:0] ELAPSED_MAX = 10'h3FF;
	localparam logic [3:0] RETRY_MAX   = 4'hF;

	// register reset values
	localparam logic [6:0] DEVICE_ADDRESS_RST     = 7'd56;
	localparam logic [7:0] RESET_WAIT_MS_RST      = 8'd20;
	localparam logic [7:0] SETTLE_WAIT_MS_RST     = 8'd40;
	localparam logic [3:0] POLL_RETRIES_RST       = 4'd5;
	localparam logic [7:0] RETRY_WAIT_MS_RST      = 8'd20;
	localparam logic [9:0] MEASURE_TIMEOUT_MS_RST = 10'd100;

	typedef enum logic [2:0] {
		REG_DEVICE_ADDRESS     = 3'd0,
		REG_RESET_WAIT_MS      = 3'd1,
		REG_SETTLE_WAIT_MS     = 3'd2,
		REG_POLL_RETRIES       = 3'd3,
		REG_RETRY_WAIT_MS      = 3'd4,
		REG_MEASURE_TIMEOUT_MS = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [6:0] device_address;
		logic [7:0] reset_wait_ms;
		logic [7:0] settle_wait_ms;
		logic [3:0] poll_retries;
		logic [7:0] retry_wait_ms;
		logic [9:0] measure_timeout_ms;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_TICK     = 2'd0,
		CMD_INIT     = 2'd1,
		CMD_MEASURE  = 2'd2,
		CMD_BUS_DONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_BUS_REQ   = 2'd0,
		KIND_INIT_DONE = 2'd1,
		KIND_MEAS_DONE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOT_INIT = 2'd1,
		ST_BUS_ERR  = 2'd2,
		ST_TIMEOUT  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_TX   = 4'd1,
		PH_RST_WAIT = 4'd2,
		PH_SETTLE   = 4'd3,
		PH_IPOLL_W  = 4'd4,
		PH_IPOLL_R  = 4'd5,
		PH_IRETRY   = 4'd6,
		PH_TRIG     = 4'd7,
		PH_MPOLL_W  = 4'd8,
		PH_MPOLL_R  = 4'd9,
		PH_MFAIL    = 4'd10,
		PH_MREAD    = 4'd11
	} phase_t;

	// what the step produces
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_REQ_RESET,
		ACT_REQ_TRIG,
		ACT_REQ_STATUS_WR,
		ACT_REQ_STATUS_RD,
		ACT_REQ_READ6,
		ACT_INIT_DONE,
		ACT_MEAS_DONE,
		ACT_MEAS_DATA
	} act_t;

	typedef struct packed {
		kind_t       kind;
		status_t     status;
		logic [7:0]  address_byte;
		logic [23:0] tx_bytes;
		logic [1:0]  tx_count;
		logic [2:0]  rx_count;
		logic        calibrated;
		logic [13:0] humidity_centi;
		logic [14:0] temperature_centi;
		logic [19:0] hum_raw;
		logic [19:0] temp_raw;
	} res_t;

endpackage

// File: sv/hts_conv.sv
// Raw sample unpack and fixed-point conversion to hundredths.
// Depends on hts_pkg.
module hts_conv
	import hts_pkg::*;
(
	input  logic        [47:0] rx_data,
	output logic        [13:0] humidity_centi,
	output logic signed [14:0] temperature_centi,
	output logic        [19:0] hum_raw,
	output logic        [19:0] temp_raw
);

	logic [PROD_W-1:0] hum_prod;
	logic [PROD_W-1:0] temp_prod;
	logic [15:0]       hum_full;
	logic [15:0]       temp_full;

	assign hum_raw  = rx_data[39:20];
	assign temp_raw = rx_data[19:0];

	assign hum_prod  = PROD_W'(hum_raw) * HUM_SCALE + ROUND_HALF;
	assign temp_prod = PROD_W'(temp_raw) * TEMP_SCALE + ROUND_HALF;
	assign hum_full  = hum_prod[35:20];
	assign temp_full = temp_prod[35:20];

	// clamp to 100.00 %
	assign humidity_centi    = (hum_full > HUM_MAX) ? HUM_MAX[13:0] : hum_full[13:0];
	// offset -50.00 C, wraps in 15 bits
	assign temperature_centi = signed'(temp_full[14:0] - TEMP_OFFSET);

endmodule

// File: sv/hts_regs.sv
// APB configuration register file for the sensor sequencer.
// Depends on hts_pkg.
module hts_regs
	import hts_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address     <= DEVICE_ADDRESS_RST;
			cfg_q.reset_wait_ms      <= RESET_WAIT_MS_RST;
			cfg_q.settle_wait_ms     <= SETTLE_WAIT_MS_RST;
			cfg_q.poll_retries       <= POLL_RETRIES_RST;
			cfg_q.retry_wait_ms      <= RETRY_WAIT_MS_RST;
			cfg_q.measure_timeout_ms <= MEASURE_TIMEOUT_MS_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_DEVICE_ADDRESS:     cfg_q.device_address     <= pwdata[6:0];
				REG_RESET_WAIT_MS:      cfg_q.reset_wait_ms      <= pwdata[7:0];
				REG_SETTLE_WAIT_MS:     cfg_q.settle_wait_ms     <= pwdata[7:0];
				REG_POLL_RETRIES:       cfg_q.poll_retries       <= pwdata[3:0];
				REG_RETRY_WAIT_MS:      cfg_q.retry_wait_ms      <= pwdata[7:0];
				REG_MEASURE_TIMEOUT_MS: cfg_q.measure_timeout_ms <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DEVICE_ADDRESS:     prdata = APB_DATA_W'(cfg_q.device_address);
			REG_RESET_WAIT_MS:      prdata = APB_DATA_W'(cfg_q.reset_wait_ms);
			REG_SETTLE_WAIT_MS:     prdata = APB_DATA_W'(cfg_q.settle_wait_ms);
			REG_POLL_RETRIES:       prdata = APB_DATA_W'(cfg_q.poll_retries);
			REG_RETRY_WAIT_MS:      prdata = APB_DATA_W'(cfg_q.retry_wait_ms);
			REG_MEASURE_TIMEOUT_MS: prdata = APB_DATA_W'(cfg_q.measure_timeout_ms);
			default:                prdata = '0;
		endcase
	end

endmodule

// File: sv/hts_core.sv
// Sequencer state machine: one event per step, produces at most one result.
// Depends on hts_pkg and hts_conv.
module hts_core
	import hts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        step_en,
	input  cmd_t        cmd,
	input  logic        bus_ok,
	input  logic [47:0] rx_data,
	output logic        res_valid,
	output res_t        res
);

	phase_t     phase_q, phase_d;
	logic       init_q, init_d;
	logic [7:0] wait_q, wait_d;
	logic [3:0] retry_q, retry_d;
	logic [9:0] elapsed_q, elapsed_d;
	logic       cal_q, cal_d;

	act_t       act;
	status_t    fin_status;
	logic       go_settle, go_fail, go_retry, go_ipoll, go_mpoll;

	logic        [13:0] hum_c;
	logic signed [14:0] temp_c;
	logic        [19:0] raw_h;
	logic        [19:0] raw_t;

	hts_conv u_conv (
		.rx_data           (rx_data),
		.humidity_centi    (hum_c),
		.temperature_centi (temp_c),
		.hum_raw           (raw_h),
		.temp_raw          (raw_t)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			init_q    <= 1'b0;
			wait_q    <= '0;
			retry_q   <= '0;
			elapsed_q <= '0;
			cal_q     <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			init_q    <= init_d;
			wait_q    <= wait_d;
			retry_q   <= retry_d;
			elapsed_q <= elapsed_d;
			cal_q     <= cal_d;
		end
	end

	// next state; chained follow-ups (zero waits, poll checks) resolve in the same step
	always_comb begin
		phase_d    = phase_q;
		init_d     = init_q;
		wait_d     = wait_q;
		retry_d    = retry_q;
		elapsed_d  = elapsed_q;
		cal_d      = cal_q;
		act        = ACT_NONE;
		fin_status = ST_OK;
		go_settle  = 1'b0;
		go_fail    = 1'b0;
		go_retry   = 1'b0;
		go_ipoll   = 1'b0;
		go_mpoll   = 1'b0;

		if (step_en) begin
			unique case (cmd)
				CMD_INIT: begin
					init_d    = 1'b0;
					retry_d   = '0;
					cal_d     = 1'b0;
					elapsed_d = '0;
					wait_d    = '0;
					phase_d   = PH_RST_TX;
					act       = ACT_REQ_RESET;
				end
				CMD_MEASURE: begin
					if (phase_q == PH_IDLE) begin
						if (!init_q) begin
							act        = ACT_MEAS_DONE;
							fin_status = ST_NOT_INIT;
						end else begin
							elapsed_d = '0;
							phase_d   = PH_TRIG;
							act       = ACT_REQ_TRIG;
						end
					end
				end
				CMD_TICK: begin
					case (phase_q) inside
						PH_MPOLL_W, PH_MPOLL_R, PH_MFAIL: begin
							if (elapsed_q != ELAPSED_MAX)
								elapsed_d = elapsed_q + 10'd1;
							go_mpoll = (phase_q == PH_MFAIL);
						end
						PH_RST_WAIT, PH_SETTLE, PH_IRETRY: begin
							if (wait_q != '0)
								wait_d = wait_q - 8'd1;
							if (wait_d == '0) begin
								go_settle = (phase_q == PH_RST_WAIT);
								go_ipoll  = (phase_q == PH_SETTLE);
								go_retry  = (phase_q == PH_IRETRY);
							end
						end
						default: ;
					endcase
				end
				CMD_BUS_DONE: begin
					case (phase_q)
						PH_RST_TX: begin
							if (bus_ok && cfg.reset_wait_ms != '0) begin
								wait_d  = cfg.reset_wait_ms;
								phase_d = PH_RST_WAIT;
							end else begin
								go_settle = 1'b1;   // failed reset skips the wait
							end
						end
						PH_IPOLL_W: begin
							if (!bus_ok) begin
								go_fail = 1'b1;
							end else begin
								phase_d = PH_IPOLL_R;
								act     = ACT_REQ_STATUS_RD;
							end
						end
						PH_IPOLL_R: begin
							if (!bus_ok) begin
								go_fail = 1'b1;
							end else begin
								cal_d = rx_data[CAL_BIT];
								if (!rx_data[BUSY_BIT]) begin
									init_d  = 1'b1;
									phase_d = PH_IDLE;
									act     = ACT_INIT_DONE;
								end else begin
									go_fail = 1'b1;
								end
							end
						end
						PH_TRIG: begin
							if (!bus_ok) begin
								phase_d    = PH_IDLE;
								act        = ACT_MEAS_DONE;
								fin_status = ST_BUS_ERR;
							end else begin
								elapsed_d = '0;
								go_mpoll  = 1'b1;
							end
						end
						PH_MPOLL_W: begin
							if (!bus_ok) begin
								phase_d = PH_MFAIL;
							end else begin
								phase_d = PH_MPOLL_R;
								act     = ACT_REQ_STATUS_RD;
							end
						end
						PH_MPOLL_R: begin
							if (!bus_ok) begin
								phase_d = PH_MFAIL;
							end else if (rx_data[BUSY_BIT]) begin
								go_mpoll = 1'b1;
							end else begin
								phase_d = PH_MREAD;
								act     = ACT_REQ_READ6;
							end
						end
						PH_MREAD: begin
							phase_d = PH_IDLE;
							if (!bus_ok) begin
								act        = ACT_MEAS_DONE;
								fin_status = ST_BUS_ERR;
							end else begin
								act = ACT_MEAS_DATA;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end

		if (go_settle) begin
			wait_d = cfg.settle_wait_ms;
			if (wait_d == '0)
				go_ipoll = 1'b1;
			else
				phase_d = PH_SETTLE;
		end
		if (go_fail) begin
			wait_d = cfg.retry_wait_ms;
			if (wait_d == '0)
				go_retry = 1'b1;
			else
				phase_d = PH_IRETRY;
		end
		if (go_retry) begin
			if (retry_d != RETRY_MAX)
				retry_d = retry_d + 4'd1;
			go_ipoll = 1'b1;
		end
		if (go_ipoll) begin
			if (retry_d >= cfg.poll_retries) begin
				// tries used up: finish initialized anyway
				init_d     = 1'b1;
				phase_d    = PH_IDLE;
				act        = ACT_INIT_DONE;
				fin_status = ST_TIMEOUT;
			end else begin
				phase_d = PH_IPOLL_W;
				act     = ACT_REQ_STATUS_WR;
			end
		end
		if (go_mpoll) begin
			if (elapsed_d >= cfg.measure_timeout_ms) begin
				phase_d    = PH_IDLE;
				act        = ACT_MEAS_DONE;
				fin_status = ST_TIMEOUT;
			end else begin
				phase_d = PH_MPOLL_W;
				act     = ACT_REQ_STATUS_WR;
			end
		end
	end

	// result fields from the chosen action
	always_comb begin
		res       = '0;
		res_valid = (act != ACT_NONE);
		unique case (act)
			ACT_REQ_RESET: begin
				res.kind         = KIND_BUS_REQ;
				res.address_byte = {cfg.device_address, 1'b0};
				res.tx_bytes     = {16'h0000, SOFT_RESET_CMD};
				res.tx_count     = 2'd1;
			end
			ACT_REQ_TRIG: begin
				res.kind         = KIND_BUS_REQ;
				res.address_byte = {cfg.device_address, 1'b0};
				res.tx_bytes     = TRIGGER_CMD;
				res.tx_count     = 2'd3;
			end
			ACT_REQ_STATUS_WR: begin
				res.kind         = KIND_BUS_REQ;
				res.address_byte = {cfg.device_address, 1'b0};
				res.tx_bytes     = {16'h0000, STATUS_CMD};
				res.tx_count     = 2'd1;
			end
			ACT_REQ_STATUS_RD: begin
				res.kind         = KIND_BUS_REQ;
				res.address_byte = {cfg.device_address, 1'b1};
				res.rx_count     = 3'd1;
			end
			ACT_REQ_READ6: begin
				res.kind         = KIND_BUS_REQ;
				res.address_byte = {cfg.device_address, 1'b1};
				res.rx_count     = 3'd6;
			end
			ACT_INIT_DONE: begin
				res.kind       = KIND_INIT_DONE;
				res.status     = fin_status;
				res.calibrated = cal_d;
			end
			ACT_MEAS_DONE: begin
				res.kind   = KIND_MEAS_DONE;
				res.status = fin_status;
			end
			ACT_MEAS_DATA: begin
				res.kind              = KIND_MEAS_DONE;
				res.status            = ST_OK;
				res.humidity_centi    = hum_c;
				res.temperature_centi = temp_c;
				res.hum_raw           = raw_h;
				res.temp_raw          = raw_t;
			end
			default: ;
		endcase
	end

	// a finished init always leaves the block initialized and idle
	a_init_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_INIT_DONE |=> init_q && phase_q == PH_IDLE)
		else $error("init finished without setting initialized");

endmodule

// File: sv/humidity_temp_sensor_sequencer.sv
// Top level of the humidity/temperature sensor read sequencer.
// Depends on hts_pkg, hts_regs, hts_core (and hts_conv below it).

// The block steers an external two-wire bus master for a humidity and
// temperature sensor. Each input transaction is one event: a 1 ms tick, a
// start-init or start-measure command, or the master's report of a finished
// bus transaction (ack flag plus received bytes). Each event yields zero or
// one output transaction: a bus request for the master, an init-finished
// notice, or a measurement result with humidity and temperature in
// hundredths. Throughput is one event per clock while the output is not
// stalled. An accepted event sits in the input register while the
// combinational sequencer step resolves it, and its result is written into
// the output register, which drives m_tvalid. The step itself is the only
// work between the two registers; the output register lets the next event
// be taken while a result still waits, and a stalled output holds the input
// register and drops s_tready. The user must write the registers over APB
// only while the sequencer is idle; the block itself does not enforce it.
// There is no clearing pass after reset.
module humidity_temp_sensor_sequencer
	import hts_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [55:0]           s_tdata,   // bus_ok[0], rx_data[48:1], zero pad
	input  logic [1:0]            s_tuser,   // cmd[1:0]

	output logic                  m_tvalid,
	input  logic                  m_tready,
	// status[1:0], address_byte[9:2], tx_bytes[33:10], tx_count[35:34],
	// rx_count[38:36], calibrated[39], humidity_centi[53:40],
	// temperature_centi[68:54], hum_raw[88:69], temp_raw[108:89], pad
	output logic [111:0]          m_tdata,
	output logic [1:0]            m_tuser,   // kind[1:0]

	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t        cfg;

	// input register
	logic        valid_s1;
	cmd_t        cmd_s1;
	logic        ok_s1;
	logic [47:0] rx_s1;

	// output register
	logic        out_valid_q;
	res_t        out_q;

	logic        step_en;   // event in s1 is consumed this cycle
	logic        res_valid;
	res_t        res;
	logic        in_take;

	hts_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hts_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step_en   (step_en),
		.cmd       (cmd_s1),
		.bus_ok    (ok_s1),
		.rx_data   (rx_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// the step may run only if the output slot is free or drains now
	assign step_en  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step_en;
	assign in_take  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1 <= cmd_t'(s_tuser);
			ok_s1  <= s_tdata[0];
			rx_s1  <= s_tdata[48:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step_en && res_valid)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step_en && res_valid)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {3'b000, out_q.temp_raw, out_q.hum_raw,
		out_q.temperature_centi, out_q.humidity_centi, out_q.calibrated,
		out_q.rx_count, out_q.tx_count, out_q.tx_bytes, out_q.address_byte,
		out_q.status};

	// a held event must block new input while the result slot is stuck
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |-> !s_tready)
		else $error("input accepted while step is stalled");

	// every bus request moves at least one byte
	a_req_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == KIND_BUS_REQ |-> out_q.tx_count != 2'd0
		|| out_q.rx_count != 3'd0)
		else $error("empty bus request");

	// read requests carry no write bytes
	a_read_no_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == KIND_BUS_REQ && out_q.address_byte[0]
		|-> out_q.tx_count == 2'd0)
		else $error("read request with write bytes");

	// humidity stays clamped
	a_hum_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == KIND_MEAS_DONE |-> out_q.humidity_centi <= HUM_MAX[13:0])
		else $error("humidity above 100 percent");

endmodule

// File: tb/humidity_temp_sensor_sequencer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for humidity_temp_sensor_sequencer: drives event transactions,
// plays the bus master and programs the APB registers. Uses hts_pkg types and the RTL only.
// A scoreboard class predicts every result transaction and checks the output stream.

module humidity_temp_sensor_sequencer_test;
	import hts_pkg::*;

	// sensor protocol bytes, kept local so the prediction does not lean on the RTL package
	localparam logic [23:0] SOFT_RESET_BYTE = 24'h0000BA;
	localparam logic [23:0] STATUS_BYTE     = 24'h000071;
	localparam logic [23:0] TRIGGER_BYTES   = 24'hAC3300;
	localparam logic [47:0] ALL_ONES        = {48{1'b1}};
	localparam int          DRAIN_SLACK     = 4;     // cycles after the last result before APB
	localparam int          RUN_LIMIT_NS    = 5_000_000;

	// ------------------------------------------------------------------------
	// Scoreboard: own copy of the sequencer state and registers, a queue of
	// predicted result transactions, and the field-by-field comparison.
	// ------------------------------------------------------------------------
	class sequencer_scoreboard;
		cfg_t       cfg;
		phase_t     ph;
		bit         inited;
		bit         cal;
		logic [7:0] wait_cnt;
		logic [3:0] tries;
		logic [9:0] elapsed;
		res_t       expected_results[$];
		int         errors, n_events, n_results, n_init_ends, n_readings, n_timeouts, n_bus_err;

		function new();
			cfg = '{DEVICE_ADDRESS_RST, RESET_WAIT_MS_RST, SETTLE_WAIT_MS_RST,
				POLL_RETRIES_RST, RETRY_WAIT_MS_RST, MEASURE_TIMEOUT_MS_RST};
			ph = PH_IDLE;
			inited = 0;
			cal = 0;
			wait_cnt = '0;
			tries = '0;
			elapsed = '0;
		endfunction

		function void set_reg(reg_idx_t r, logic [31:0] v);
			case (r)
				REG_DEVICE_ADDRESS:     cfg.device_address = v[6:0];
				REG_RESET_WAIT_MS:      cfg.reset_wait_ms = v[7:0];
				REG_SETTLE_WAIT_MS:     cfg.settle_wait_ms = v[7:0];
				REG_POLL_RETRIES:       cfg.poll_retries = v[3:0];
				REG_RETRY_WAIT_MS:      cfg.retry_wait_ms = v[7:0];
				REG_MEASURE_TIMEOUT_MS: cfg.measure_timeout_ms = v[9:0];
				default: ;
			endcase
		endfunction

		function int outstanding();
			return expected_results.size();
		endfunction

		function res_t bus_req(bit rd, logic [23:0] tx, logic [1:0] txc, logic [2:0] rxc);
			res_t r;
			r = '0;
			r.kind = KIND_BUS_REQ;
			r.address_byte = {cfg.device_address, rd};
			r.tx_bytes = tx;
			r.tx_count = txc;
			r.rx_count = rxc;
			return r;
		endfunction

		function res_t wrap_up(kind_t k, status_t s);
			res_t r;
			r = '0;
			r.kind = k;
			r.status = s;
			ph = PH_IDLE;
			return r;
		endfunction

		function res_t init_end(status_t s);
			res_t r;
			inited = 1;
			r = wrap_up(KIND_INIT_DONE, s);
			r.calibrated = cal;
			return r;
		endfunction

		// status poll during init, or forced end once the tries are used up
		function res_t init_poll();
			if (tries >= cfg.poll_retries)
				return init_end(ST_TIMEOUT);
			ph = PH_IPOLL_W;
			return bus_req(1'b0, STATUS_BYTE, 2'd1, 3'd0);
		endfunction

		function res_t retry_now();
			if (tries < 4'hF)
				tries++;
			return init_poll();
		endfunction

		function bit enter_settle(output res_t r);
			wait_cnt = cfg.settle_wait_ms;
			if (wait_cnt == 0) begin
				r = init_poll();
				return 1;
			end
			ph = PH_SETTLE;
			return 0;
		endfunction

		function bit init_fail(output res_t r);
			wait_cnt = cfg.retry_wait_ms;
			if (wait_cnt == 0) begin
				r = retry_now();
				return 1;
			end
			ph = PH_IRETRY;
			return 0;
		endfunction

		function res_t meas_poll();
			if (elapsed >= cfg.measure_timeout_ms)
				return wrap_up(KIND_MEAS_DONE, ST_TIMEOUT);
			ph = PH_MPOLL_W;
			return bus_req(1'b0, STATUS_BYTE, 2'd1, 3'd0);
		endfunction

		// fixed-point conversion of the six data bytes: round to nearest, then offset/clamp
		function res_t reading(logic [47:0] rx);
			res_t r;
			logic [63:0] rh, rt, h, t;
			rh = {44'd0, rx[39:20]};
			rt = {44'd0, rx[19:0]};
			h = (rh * 64'd10000 + 64'h80000) >> 20;
			t = (rt * 64'd20000 + 64'h80000) >> 20;
			if (h > 64'd10000)
				h = 64'd10000;
			r = wrap_up(KIND_MEAS_DONE, ST_OK);
			r.humidity_centi = h[13:0];
			r.temperature_centi = t[14:0] - 15'd5000;
			r.hum_raw = rh[19:0];
			r.temp_raw = rt[19:0];
			return r;
		endfunction

		// one event through the sequencer; returns 1 when a result transaction follows
		function bit predict_step(cmd_t c, bit ok, logic [47:0] rx, output res_t r);
			logic [7:0] sb;
			sb = rx[7:0];
			r = '0;
			case (c)
				CMD_INIT: begin
					inited = 0;
					tries = '0;
					cal = 0;
					elapsed = '0;
					wait_cnt = '0;
					ph = PH_RST_TX;
					r = bus_req(1'b0, SOFT_RESET_BYTE, 2'd1, 3'd0);
					return 1;
				end
				CMD_MEASURE: begin
					if (ph != PH_IDLE)
						return 0;
					if (!inited) begin
						r = wrap_up(KIND_MEAS_DONE, ST_NOT_INIT);
						return 1;
					end
					elapsed = '0;
					ph = PH_TRIG;
					r = bus_req(1'b0, TRIGGER_BYTES, 2'd3, 3'd0);
					return 1;
				end
				CMD_TICK: begin
					if (ph == PH_MPOLL_W || ph == PH_MPOLL_R || ph == PH_MFAIL) begin
						if (elapsed < 10'h3FF)
							elapsed++;
						if (ph == PH_MFAIL) begin
							r = meas_poll();
							return 1;
						end
						return 0;
					end
					if (ph == PH_RST_WAIT || ph == PH_SETTLE || ph == PH_IRETRY) begin
						if (wait_cnt > 0)
							wait_cnt--;
						if (wait_cnt != 0)
							return 0;
						if (ph == PH_RST_WAIT)
							return enter_settle(r);
						if (ph == PH_SETTLE)
							r = init_poll();
						else
							r = retry_now();
						return 1;
					end
					return 0;
				end
				default: begin
					case (ph)
						PH_RST_TX: begin
							if (ok && cfg.reset_wait_ms != 0) begin
								wait_cnt = cfg.reset_wait_ms;
								ph = PH_RST_WAIT;
								return 0;
							end
							return enter_settle(r);
						end
						PH_IPOLL_W: begin
							if (!ok)
								return init_fail(r);
							ph = PH_IPOLL_R;
							r = bus_req(1'b1, 24'd0, 2'd0, 3'd1);
							return 1;
						end
						PH_IPOLL_R: begin
							if (!ok)
								return init_fail(r);
							cal = sb[3];
							if (!sb[7]) begin
								r = init_end(ST_OK);
								return 1;
							end
							return init_fail(r);
						end
						PH_TRIG: begin
							if (!ok)
								r = wrap_up(KIND_MEAS_DONE, ST_BUS_ERR);
							else begin
								elapsed = '0;
								r = meas_poll();
							end
							return 1;
						end
						PH_MPOLL_W, PH_MPOLL_R: begin
							if (!ok) begin
								ph = PH_MFAIL;
								return 0;
							end
							if (ph == PH_MPOLL_W) begin
								ph = PH_MPOLL_R;
								r = bus_req(1'b1, 24'd0, 2'd0, 3'd1);
							end else if (sb[7]) begin
								r = meas_poll();
							end else begin
								ph = PH_MREAD;
								r = bus_req(1'b1, 24'd0, 2'd0, 3'd6);
							end
							return 1;
						end
						PH_MREAD: begin
							if (!ok)
								r = wrap_up(KIND_MEAS_DONE, ST_BUS_ERR);
							else
								r = reading(rx);
							return 1;
						end
						default: return 0;
					endcase
				end
			endcase
		endfunction

		// accepted event: queue its result, report whether the block did anything with it
		function bit note_event(cmd_t c, bit ok, logic [47:0] rx);
			res_t r;
			bit got;
			logic [27:0] prior;
			prior = {ph, inited, cal, wait_cnt, tries, elapsed};
			got = predict_step(c, ok, rx, r);
			n_events++;
			if (got)
				expected_results.push_back(r);
			return got || (prior != {ph, inited, cal, wait_cnt, tries, elapsed});
		endfunction

		function void cmp(string name, logic [63:0] e, logic [63:0] a);
			if (e !== a) begin
				errors++;
				$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, e, a);
			end
		endfunction

		function void check_result(logic [1:0] user, logic [111:0] d);
			res_t e, a;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t ns: result transaction with nothing expected, kind %0d data %0h",
					$time, user, d);
				return;
			end
			e = expected_results.pop_front();
			a = res_t'({user, d[1:0], d[9:2], d[33:10], d[35:34], d[38:36], d[39],
				d[53:40], d[68:54], d[88:69], d[108:89]});
			n_results++;
			if (e.kind == KIND_INIT_DONE)
				n_init_ends++;
			if (e.kind == KIND_MEAS_DONE && e.status == ST_OK)
				n_readings++;
			if (e.status == ST_TIMEOUT)
				n_timeouts++;
			if (e.status == ST_BUS_ERR)
				n_bus_err++;
			cmp("kind", 64'(e.kind), 64'(a.kind));
			cmp("status", 64'(e.status), 64'(a.status));
			cmp("address_byte", 64'(e.address_byte), 64'(a.address_byte));
			cmp("tx_bytes", 64'(e.tx_bytes), 64'(a.tx_bytes));
			cmp("tx_count", 64'(e.tx_count), 64'(a.tx_count));
			cmp("rx_count", 64'(e.rx_count), 64'(a.rx_count));
			cmp("calibrated", 64'(e.calibrated), 64'(a.calibrated));
			cmp("humidity_centi", 64'(e.humidity_centi), 64'(a.humidity_centi));
			cmp("temperature_centi", 64'(e.temperature_centi), 64'(a.temperature_centi));
			cmp("hum_raw", 64'(e.hum_raw), 64'(a.hum_raw));
			cmp("temp_raw", 64'(e.temp_raw), 64'(a.temp_raw));
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup; every input starts at a known value
	// ------------------------------------------------------------------------
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [55:0]           s_tdata = '0;    // bus_ok[0], rx_data[48:1], zero pad
	logic [1:0]            s_tuser = '0;    // cmd[1:0]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [111:0]          m_tdata;         // status, address_byte, tx_bytes, ... temp_raw
	logic [1:0]            m_tuser;         // kind[1:0]
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	sequencer_scoreboard sb;
	bit src_gaps;          // sender idles between transactions when set
	bit sink_stalls = 0;   // receiver drops m_tready at random when set
	bit took_effect;       // last accepted event was not merely ignored
	int stall_left = 0;
	int n_settings = 0;

	humidity_temp_sensor_sequencer uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random back-pressure bursts, mostly short ones and now and then a long one.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (sink_stalls && $urandom_range(0, 99) < 30) begin
			m_tready <= 1'b0;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Output monitor: values sampled at the edge are the ones before any update there.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Block until every predicted result has been seen; the #1 keeps the test
	// clear of the monitor popping the queue at the same edge.
	task automatic wait_empty();
		do begin
			@(posedge clk);
			#1;
		end while (sb.outstanding() != 0);
		@(posedge clk);
	endtask

	task automatic pause_source(int cycles, bit drain);
		s_tvalid <= 1'b0;
		if (drain)
			wait_empty();
		repeat (cycles) @(posedge clk);
	endtask

	// One event transaction. Called at a rising edge; returns at the accepting
	// edge or after the idle gap that follows it.
	task automatic push_event(cmd_t c, bit ok, logic [47:0] rx);
		int pick;
		s_tvalid <= 1'b1;
		s_tuser <= c;
		s_tdata <= {7'd0, rx, ok};
		do @(posedge clk); while (!s_tready);
		took_effect = sb.note_event(c, ok, rx);
		if (src_gaps) begin
			pick = $urandom_range(0, 99);
			if (pick >= 99)
				pause_source(1, 1);               // hold off until the block has drained
			else if (pick >= 90)
				pause_source($urandom_range(10, 40), 0);
			else if (pick >= 55)
				pause_source($urandom_range(1, 3), 0);
		end
	endtask

	// setup, access, then a return to idle so back-to-back writes never overlap
	task automatic reg_write(reg_idx_t r, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(r, v);
		@(posedge clk);
	endtask

	task automatic apply_settings(cfg_t c);
		reg_write(REG_DEVICE_ADDRESS, 32'(c.device_address));
		reg_write(REG_RESET_WAIT_MS, 32'(c.reset_wait_ms));
		reg_write(REG_SETTLE_WAIT_MS, 32'(c.settle_wait_ms));
		reg_write(REG_POLL_RETRIES, 32'(c.poll_retries));
		reg_write(REG_RETRY_WAIT_MS, 32'(c.retry_wait_ms));
		reg_write(REG_MEASURE_TIMEOUT_MS, 32'(c.measure_timeout_ms));
	endtask

	// Pick the next event the way a bus master and a host would: answer the
	// pending bus request, tick through waits, start work when idle. A slice
	// of noise (random commands and fields) is mixed in. In tidy mode every
	// answer is a clean ack so the sequencer walks back to idle.
	task automatic random_event(int fail_pct, int busy_pct, bit tidy);
		cmd_t c;
		bit ok;
		logic [63:0] bits;
		logic [47:0] rx;
		bits = {$urandom, $urandom};
		rx = bits[47:0];
		ok = tidy || ($urandom_range(0, 99) >= fail_pct);
		if (!tidy && $urandom_range(0, 99) < 8) begin
			c = cmd_t'($urandom_range(0, 3));
			if (c == CMD_INIT && $urandom_range(0, 3) != 0)
				c = CMD_TICK;                     // restarts are costly under long waits
			ok = 1'($urandom_range(0, 1));
		end else begin
			case (sb.ph)
				PH_IDLE:
					c = (!sb.inited || $urandom_range(0, 9) == 0) ? CMD_INIT : CMD_MEASURE;
				PH_RST_WAIT, PH_SETTLE, PH_IRETRY, PH_MFAIL:
					c = CMD_TICK;
				default: begin
					c = CMD_BUS_DONE;
					// time keeps running while the busy poll goes on
					if (!tidy && (sb.ph == PH_MPOLL_W || sb.ph == PH_MPOLL_R)
							&& $urandom_range(0, 99) < 30)
						c = CMD_TICK;
					if (sb.ph == PH_IPOLL_R || sb.ph == PH_MPOLL_R)
						rx[7] = !tidy && ($urandom_range(0, 99) < busy_pct);
				end
			endcase
		end
		push_event(c, ok, rx);
	endtask

	// Bring the sequencer back to idle, then let the output side drain.
	task automatic tidy_up();
		while (sb.ph != PH_IDLE)
			random_event(0, 0, 1);
		pause_source(DRAIN_SLACK, 1);
	endtask

	task automatic run_setting(cfg_t c, int budget, int fail_pct, int busy_pct);
		int done_items;
		done_items = 0;
		apply_settings(c);
		n_settings++;
		src_gaps = 1'($urandom_range(0, 1));
		sink_stalls <= 1'($urandom_range(0, 1));
		while (done_items < budget) begin
			random_event(fail_pct, busy_pct, 0);
			if (took_effect)
				done_items++;
			// switch idling on and off now and then so quiet stretches occur too
			if ($urandom_range(0, 49) == 0)
				src_gaps = !src_gaps;
			if ($urandom_range(0, 49) == 0)
				sink_stalls <= !sink_stalls;
		end
		tidy_up();
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		sb = new();
		src_gaps = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under small settings: zero waits, a single poll try,
		// a one-tick measurement timeout.
		apply_settings('{7'd0, 8'd0, 8'd0, 4'd1, 8'd0, 10'd1});
		n_settings++;
		sink_stalls <= 1;
		push_event(CMD_TICK, 1, ALL_ONES);          // tick while idle: ignored
		push_event(CMD_BUS_DONE, 1, 48'd0);         // bus done with nothing pending
		push_event(CMD_MEASURE, 0, 48'd0);          // not initialized yet
		push_event(CMD_INIT, 0, 48'd0);
		push_event(CMD_BUS_DONE, 0, 48'd0);         // soft reset not acked: wait skipped
		push_event(CMD_BUS_DONE, 1, 48'd0);
		push_event(CMD_BUS_DONE, 1, ALL_ONES);      // busy, tries used up: forced end
		push_event(CMD_MEASURE, 0, 48'd0);
		push_event(CMD_MEASURE, 0, 48'd0);          // already busy: ignored
		push_event(CMD_BUS_DONE, 1, 48'd0);
		push_event(CMD_BUS_DONE, 0, 48'd0);         // failed poll, then one tick
		push_event(CMD_TICK, 0, 48'd0);             // timeout reached
		push_event(CMD_MEASURE, 0, 48'd0);
		push_event(CMD_BUS_DONE, 0, 48'd0);         // trigger not acked
		push_event(CMD_INIT, 1, 48'd0);
		push_event(CMD_BUS_DONE, 1, 48'd0);
		push_event(CMD_BUS_DONE, 1, 48'd0);
		push_event(CMD_BUS_DONE, 1, 48'h000000000008); // ready and calibrated
		push_event(CMD_MEASURE, 0, 48'd0);
		push_event(CMD_BUS_DONE, 1, 48'd0);
		push_event(CMD_BUS_DONE, 1, 48'd0);
		push_event(CMD_BUS_DONE, 1, 48'd0);         // not busy: six-byte read
		push_event(CMD_BUS_DONE, 1, 48'd0);         // coldest and driest reading
		push_event(CMD_MEASURE, 0, 48'd0);
		push_event(CMD_BUS_DONE, 1, ALL_ONES);
		push_event(CMD_BUS_DONE, 1, ALL_ONES);
		push_event(CMD_BUS_DONE, 1, 48'hFFFFFFFFFF7F);
		push_event(CMD_BUS_DONE, 1, ALL_ONES);      // hottest and wettest reading
		push_event(CMD_MEASURE, 0, 48'd0);
		push_event(CMD_INIT, 0, 48'd0);             // init aborts a running measurement
		tidy_up();

		// Random part over several register settings, extremes included.
		run_setting('{7'd56, 8'd20, 8'd40, 4'd5, 8'd20, 10'd100}, 90, 15, 40);
		run_setting('{7'd0, 8'd0, 8'd0, 4'd1, 8'd0, 10'd1}, 50, 25, 50);
		run_setting('{7'd127, 8'd255, 8'd1, 4'd15, 8'd1, 10'd1023}, 120, 20, 60);
		run_setting('{7'd42, 8'd1, 8'd255, 4'd0, 8'd3, 10'd0}, 60, 20, 50);
		run_setting('{7'd85, 8'd3, 8'd2, 4'd1, 8'd255, 10'd7}, 80, 30, 60);

		repeat (10) @(posedge clk);
		if (sb.outstanding() != 0) begin
			sb.errors++;
			$display("%0t ns: %0d expected results never arrived", $time, sb.outstanding());
		end
		$display("Covered %0d events over %0d register settings, %0d results checked.",
			sb.n_events, n_settings, sb.n_results);
		$display("Init ends %0d, readings %0d, timeouts %0d, bus errors %0d, mismatches %0d.",
			sb.n_init_ends, sb.n_readings, sb.n_timeouts, sb.n_bus_err, sb.errors);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog: far above the slowest legal run.
	initial begin
		#(RUN_LIMIT_NS);
		$display("%0t ns: watchdog expired, %0d results still expected", $time,
			sb.outstanding());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: humidity_temp_sensor_sequencer.f
sv/hts_pkg.sv
sv/hts_conv.sv
sv/hts_regs.sv
sv/hts_core.sv
sv/humidity_temp_sensor_sequencer.sv
tb/humidity_temp_sensor_sequencer_test.sv
